/* src/fba_pkg.sv */
// fba_pkg: shared types, constants and helpers of the frame bitmap allocator
// no dependencies
`timescale 1ns / 1ps

package fba_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int FRAME_W   = 12;
   localparam int CNT_W     = 13;
   localparam int STATUS_W  = 2;
   localparam int SCAN_W    = 9;

   localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};
   localparam logic [CNT_W-1:0]     CNT_RESET = 13'd4096;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd2;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame_number;
      logic                present_bit;
      logic                write_bit;
      logic                user_bit;
      logic [STATUS_W-1:0] status;
   } res_type;

   // index of the lowest clear bit, word must not be full
   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* src/fba_ram.sv */
// fba_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fba_engine.sv */
// fba_engine: sequencer that clears, scans and updates the frame bitmap ram
// depends on fba_pkg; drives the ports of one fba_ram
`timescale 1ns / 1ps

module fba_engine
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = 4096,
   parameter int WORDS      = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS,
   parameter int AW         = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_W-1:0]     frame_count,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [FRAME_W-1:0]   req_current_frame,
   input  logic                 req_is_kernel,
   input  logic                 req_writable,
   input  logic                 out_free,
   output logic                 res_load,
   output res_type              res,
   output logic                 ram_rd_en,
   output logic [AW-1:0]        ram_rd_addr,
   input  logic [WORD_BITS-1:0] ram_rd_data,
   output logic                 ram_wr_en,
   output logic [AW-1:0]        ram_wr_addr,
   output logic [WORD_BITS-1:0] ram_wr_data
);

   localparam int SEARCH_MAX = MAX_FRAMES / WORD_BITS;
   localparam int SEARCH_CAP = (SEARCH_MAX > 255) ? 255 : SEARCH_MAX;

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd3;
   localparam logic [2:0] S_FREE_WR = 3'd4;
   localparam logic [2:0] S_RESULT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [FRAME_W-1:0] cur_ff, cur_in;
   logic               kern_ff, kern_in;
   logic               wr_ff, wr_in;
   logic [SCAN_W-1:0]  limit_ff, limit_in;
   logic [SCAN_W-1:0]  issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [SCAN_W-1:0]  pend_addr_ff, pend_addr_in;
   res_type            res_ff, res_in;

   logic [SCAN_W-1:0]  lim;
   logic [BIT_W-1:0]   zero_idx;
   logic [AW-1:0]      free_addr;
   logic               in_range;

   // words searched: floor(frame_count / 32), capped by the bitmap size
   always_comb begin
      lim = {1'b0, frame_count[CNT_W-1:BIT_W]};
      if (lim > SCAN_W'(SEARCH_CAP)) begin
         lim = SCAN_W'(SEARCH_CAP);
      end
   end

   assign zero_idx  = lowest_zero(ram_rd_data);
   assign free_addr = AW'(cur_ff[FRAME_W-1:BIT_W]);
   assign in_range  = (32'(req_current_frame) < 32'(MAX_FRAMES));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      kern_in      = kern_ff;
      wr_in        = wr_ff;
      limit_in     = limit_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      res_in       = res_ff;
      req_ready    = 1'b0;
      res_load     = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_in   = req_current_frame;
               kern_in  = req_is_kernel;
               wr_in    = req_writable;
               limit_in = lim;
               issue_in = '0;
               pend_in  = 1'b0;
               if (req_action == ACT_ALLOC) begin
                  if (req_current_frame != '0) begin
                     res_in   = '{req_current_frame, 1'b0, 1'b0, 1'b0, ST_UNCHANGED};
                     state_in = S_RESULT;
                  end else if (lim == '0) begin
                     res_in   = '{'0, 1'b0, 1'b0, 1'b0, ST_NO_FRAME};
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_current_frame == '0) begin
                     res_in   = '{'0, 1'b0, 1'b0, 1'b0, ST_UNCHANGED};
                     state_in = S_RESULT;
                  end else begin
                     res_in   = '{'0, 1'b0, 1'b0, 1'b0, ST_DONE};
                     state_in = in_range ? S_FREE_RD : S_RESULT;
                  end
               end
            end
         end
         S_SCAN: begin
            // one word read issued per cycle, checked the cycle after
            if (issue_ff < limit_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = AW'(issue_ff);
               issue_in     = issue_ff + SCAN_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = issue_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (ram_rd_data != FULL_WORD)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(pend_addr_ff);
               ram_wr_data = ram_rd_data | (WORD_BITS'(1) << zero_idx);
               res_in      = '{FRAME_W'({pend_addr_ff, zero_idx}), 1'b1, wr_ff, !kern_ff,
                               ST_DONE};
               state_in    = S_RESULT;
            end else if (issue_ff >= limit_ff) begin
               res_in   = '{'0, 1'b0, 1'b0, 1'b0, ST_NO_FRAME};
               state_in = S_RESULT;
            end
         end
         S_FREE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = free_addr;
            state_in    = S_FREE_WR;
         end
         S_FREE_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = free_addr;
            ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << cur_ff[BIT_W-1:0]);
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
      cur_ff       <= cur_in;
      kern_ff      <= kern_in;
      wr_ff        <= wr_in;
      limit_ff     <= limit_in;
      issue_ff     <= issue_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
   end

   assign res = res_ff;

endmodule

/* src/frame_bitmap_allocator_top.sv */
// frame_bitmap_allocator_top: bitmap first-fit page frame allocator
// depends on fba_pkg, fba_engine and fba_ram
`timescale 1ns / 1ps

// usage
//   req_ channel: one beat per page entry; req_action 0 allocates a frame for an
//   empty entry (req_current_frame zero), 1 frees the entry's frame
//   rsp_ channel: exactly one beat per request, in order, with the new entry
//   bits and a status (done, no free frame, entry left unchanged)
//   csr_ port: csr_write_enable writes frame_count at once; only
//   floor(frame_count / 32) bitmap words are searched, capped by the bitmap
//   the block takes one request at a time; the bitmap lives in a one-port-write,
//   one-port-read ram; a successful allocate or an in-range free is a
//   read-modify-write of it; allocate scans from word 0 up, reading one word
//   per cycle, and sets the lowest clear bit of the first word that has one;
//   free reads the entry's word and clears its bit; an unchanged entry, an
//   out-of-range free or an empty search goes straight to the response
//   reset: a clearing pass writes zero to every bitmap word, one per cycle;
//   req_ready stays low meanwhile
//   stall: a finished response waits in the output register; the next request
//   is accepted meanwhile and its result is held until the register frees up

module frame_bitmap_allocator_top
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [CNT_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [FRAME_W-1:0]  req_current_frame,
   input  logic                req_is_kernel,
   input  logic                req_writable,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [FRAME_W-1:0]  rsp_frame_number,
   output logic                rsp_present_bit,
   output logic                rsp_write_bit,
   output logic                rsp_user_bit,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [CNT_W-1:0]     frame_count_ff, frame_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   res_type              rsp_ff, rsp_in;

   logic                 out_free;
   logic                 res_load;
   res_type              res;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;

   // frame count register
   assign frame_count_in = csr_write_enable ? csr_write_data : frame_count_ff;

   // output register frees up when empty or when its beat is taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= CNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   fba_engine #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORDS      (WORDS),
      .AW         (AW)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .frame_count       (frame_count_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_current_frame (req_current_frame),
      .req_is_kernel     (req_is_kernel),
      .req_writable      (req_writable),
      .out_free          (out_free),
      .res_load          (res_load),
      .res               (res),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data)
   );

   // used/free bitmap, one bit per frame
   fba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_ff.frame_number;
   assign rsp_present_bit  = rsp_ff.present_bit;
   assign rsp_write_bit    = rsp_ff.write_bit;
   assign rsp_user_bit     = rsp_ff.user_bit;
   assign rsp_status       = rsp_ff.status;

   // no request taken in the first cycle after reset, the clearing pass runs
   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request accepted during bitmap clear");

   // a result is only moved into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // accepting a request and delivering a result never share a cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !res_load)
      else $error("request accepted while a result is pending");

   // a present entry only comes with status done
   a_present_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_present_bit) |-> (rsp_status == ST_DONE))
      else $error("present entry with a failure status");

endmodule
